@@ hw/rtl/cgnbm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Box-Muller noise package
// Shared constants and tables for the complex Gaussian noise generator.
// ----------------------------------------------------------------------------
package cgnbm_pkg;

  localparam int UNIFORM_BITS_DEF = 16;
  localparam int ITER_STEPS       = 24;
  localparam int CORDIC_W         = 34;
  localparam int SIGMA_W          = 16;
  localparam int OUT_W            = 24;
  localparam int FRAC_Q           = 24;

  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 16'd256;
  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;

  localparam logic [31:0] ATAN_TURNS [0:ITER_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage
`default_nettype wire

@@ hw/rtl/complex_gaussian_noise_box_muller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Complex Gaussian noise generator
// Box-Muller transform in fixed point: log and CORDIC cells side by side,
// then a row of square root cells, then scaling by sigma with saturation.
// ----------------------------------------------------------------------------
//  channel | ports                                   | moves
//  in      | in_valid, in_stall, in_uniform_a/b      | one request of two codes
//  out     | out_valid, out_stall, out_noise_real/imag | one complex sample
//  cfg     | cfg_wr_en, cfg_wr_data                  | sigma, Q8.8
//
//  One request per cycle while in_stall is low; a request passes 24 log/CORDIC
//  cells and SQ square root cells (SQ = 27 at 16-bit codes), then the scaling stages.
//  Reset is synchronous and clears the stage valid bits and sigma (1.0).
//  Stalls collapse bubbles: each stage loads when empty or when the next moves.
// ----------------------------------------------------------------------------
module complex_gaussian_noise_box_muller #(
  parameter int UNIFORM_BITS = cgnbm_pkg::UNIFORM_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [15:0]                     in_uniform_a,
  input  wire logic [15:0]                     in_uniform_b,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [cgnbm_pkg::OUT_W-1:0]   out_noise_real,
  output logic signed [cgnbm_pkg::OUT_W-1:0]   out_noise_imag,
  input  wire logic                            cfg_wr_en,
  input  wire logic [cgnbm_pkg::SIGMA_W-1:0]   cfg_wr_data
);

  localparam int IT   = cgnbm_pkg::ITER_STEPS;
  localparam int CW   = cgnbm_pkg::CORDIC_W;
  localparam int UB   = UNIFORM_BITS;
  localparam int PW   = $clog2(UB + 1);
  localparam int LW   = PW + cgnbm_pkg::FRAC_Q;
  localparam int R2W  = LW + 1;
  localparam int VW   = R2W + cgnbm_pkg::FRAC_Q;
  localparam int SQ   = (VW + 1) / 2;
  localparam int TGW  = 2 * CW;
  localparam int P1W  = SQ + 1 + CW;
  localparam int TW   = P1W + 1 - 30;
  localparam int P2W  = TW + cgnbm_pkg::SIGMA_W + 1;
  localparam int OW   = P2W + 1 - 20;
  localparam int S_R2 = IT + 1;
  localparam int S_SQ = IT + 2;
  localparam int S_F1 = S_SQ + SQ;
  localparam int S_F2 = S_F1 + 1;
  localparam int S_F3 = S_F2 + 1;
  localparam int NST  = S_F3 + 1;

  // stage control
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST:0]   rdy;

  assign rdy[NST] = !out_stall;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end
  assign vld_nxt  = {vld_r[NST-2:0], in_valid};
  assign in_stall = !rdy[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // sigma register
  logic [cgnbm_pkg::SIGMA_W-1:0] sigma_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= cgnbm_pkg::SIGMA_RESET;
    end else if (cfg_wr_en) begin
      sigma_r <= cfg_wr_data;
    end
  end

  // stage 0: normalize the radius mantissa, form the phase
  logic [31:0]    a32, b32;
  logic [UB-1:0]  a_b, b_b;
  logic [UB:0]    m, n;
  logic [PW-1:0]  p_nxt;
  logic [UB+30:0] xw;
  logic [63:0]    nw;
  logic [31:0]    phase;

  always_comb begin
    a32 = 32'(in_uniform_a);
    b32 = 32'(in_uniform_b);
    a_b = a32[UB-1:0];
    b_b = b32[UB-1:0];
    m = {1'b1, {UB{1'b0}}} - {1'b0, a_b};
    n = {1'b1, {UB{1'b0}}} - {1'b0, b_b};
    p_nxt = '0;
    for (int i = 0; i <= UB; i++) begin
      if (m[i]) begin
        p_nxt = PW'(i);
      end
    end
    xw = {m, 30'b0} >> p_nxt;
    nw = 64'(n) << (32 - UB);
    phase = nw[31:0];
  end

  logic        [30:0]   lx   [0:IT];
  logic        [IT-1:0] lf   [0:IT];
  logic        [PW-1:0] lp   [0:IT];
  logic signed [CW-1:0] cx   [0:IT];
  logic signed [CW-1:0] cy   [0:IT];
  logic signed [CW-1:0] cz   [0:IT];
  logic        [1:0]    cq   [0:IT];

  logic        [30:0]   s0_x_r;
  logic        [PW-1:0] s0_p_r;
  logic signed [CW-1:0] s0_z_r;
  logic        [1:0]    s0_q_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_x_r <= xw[30:0];
      s0_p_r <= p_nxt;
      s0_z_r <= $signed(CW'(phase[29:0]));
      s0_q_r <= phase[31:30];
    end
  end

  assign lx[0] = s0_x_r;
  assign lf[0] = '0;
  assign lp[0] = s0_p_r;
  assign cx[0] = $signed(CW'(cgnbm_pkg::INV_GAIN_Q30));
  assign cy[0] = '0;
  assign cz[0] = s0_z_r;
  assign cq[0] = s0_q_r;

  for (genvar i = 0; i < IT; i++) begin : g_iter
    cgnbm_log_cell #(
      .PW(PW)
    ) u_log (
      .clk    (clk),
      .en     (rdy[i+1]),
      .x_in   (lx[i]),
      .frac_in(lf[i]),
      .p_in   (lp[i]),
      .x_r    (lx[i+1]),
      .frac_r (lf[i+1]),
      .p_r    (lp[i+1])
    );
    cgnbm_cordic_cell #(
      .IDX(i)
    ) u_cordic (
      .clk (clk),
      .en  (rdy[i+1]),
      .x_in(cx[i]),
      .y_in(cy[i]),
      .z_in(cz[i]),
      .q_in(cq[i]),
      .x_r (cx[i+1]),
      .y_r (cy[i+1]),
      .z_r (cz[i+1]),
      .q_r (cq[i+1])
    );
  end

  // -2 ln u1 and quadrant mapping
  logic [PW-1:0]        ipart;
  logic [LW-1:0]        lval;
  logic [LW+31:0]       r2p;
  logic signed [CW-1:0] c_nxt, s_nxt;
  logic [R2W-1:0]       r2_r;
  logic signed [CW-1:0] c_r, s_r;

  always_comb begin
    ipart = PW'(UB) - lp[IT];
    lval  = {ipart, {cgnbm_pkg::FRAC_Q{1'b0}}} - LW'(lf[IT]);
    r2p   = (LW+32)'(lval) * (LW+32)'(cgnbm_pkg::LN2_Q32);
    case (cq[IT])
      2'd0: begin
        c_nxt = cx[IT];
        s_nxt = cy[IT];
      end
      2'd1: begin
        c_nxt = -cy[IT];
        s_nxt = cx[IT];
      end
      2'd2: begin
        c_nxt = -cx[IT];
        s_nxt = -cy[IT];
      end
      default: begin
        c_nxt = cy[IT];
        s_nxt = -cx[IT];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[S_R2]) begin
      r2_r <= r2p[LW+31:31];
      c_r  <= c_nxt;
      s_r  <= s_nxt;
    end
  end

  // square root row
  logic [2*SQ-1:0] sv   [0:SQ];
  logic [SQ+1:0]   srem [0:SQ];
  logic [SQ-1:0]   sres [0:SQ];
  logic [TGW-1:0]  stag [0:SQ];

  assign sv[0]   = (2*SQ)'({r2_r, {cgnbm_pkg::FRAC_Q{1'b0}}});
  assign srem[0] = '0;
  assign sres[0] = '0;
  assign stag[0] = {c_r, s_r};

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    cgnbm_sqrt_cell #(
      .SQ (SQ),
      .IDX(k),
      .TW (TGW)
    ) u_sqrt (
      .clk   (clk),
      .en    (rdy[S_SQ+k]),
      .v_in  (sv[k]),
      .rem_in(srem[k]),
      .res_in(sres[k]),
      .tag_in(stag[k]),
      .v_r   (sv[k+1]),
      .rem_r (srem[k+1]),
      .res_r (sres[k+1]),
      .tag_r (stag[k+1])
    );
  end

  // scale, round and saturate; lane 0 is real, lane 1 imaginary
  logic signed [CW-1:0]    trig  [0:1];
  logic signed [P1W-1:0]   p1_r  [0:1];
  logic signed [P1W:0]     p1e   [0:1];
  logic signed [TW-1:0]    tv    [0:1];
  logic signed [P2W-1:0]   p2_r  [0:1];
  logic signed [P2W:0]     p2e   [0:1];
  logic signed [OW-1:0]    ov    [0:1];
  logic signed [cgnbm_pkg::OUT_W-1:0] sat [0:1];
  logic signed [cgnbm_pkg::OUT_W-1:0] out_real_r, out_imag_r;

  assign trig[0] = $signed(stag[SQ][TGW-1:CW]);
  assign trig[1] = $signed(stag[SQ][CW-1:0]);

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      p1e[j] = $signed({p1_r[j][P1W-1], p1_r[j]}) + $signed((P1W+1)'(64'd1 << 29));
      tv[j]  = TW'(p1e[j] >>> 30);
      p2e[j] = $signed({p2_r[j][P2W-1], p2_r[j]}) + $signed((P2W+1)'(64'd1 << 19));
      ov[j]  = OW'(p2e[j] >>> 20);
      if ((&ov[j][OW-1:cgnbm_pkg::OUT_W-1]) || !(|ov[j][OW-1:cgnbm_pkg::OUT_W-1])) begin
        sat[j] = ov[j][cgnbm_pkg::OUT_W-1:0];
      end else if (ov[j][OW-1]) begin
        sat[j] = {1'b1, {(cgnbm_pkg::OUT_W-1){1'b0}}};
      end else begin
        sat[j] = {1'b0, {(cgnbm_pkg::OUT_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      if (rdy[S_F1]) begin
        p1_r[j] <= $signed({{(P1W-SQ){1'b0}}, sres[SQ]}) *
                   $signed({{(P1W-CW){trig[j][CW-1]}}, trig[j]});
      end
      if (rdy[S_F2]) begin
        p2_r[j] <= $signed({{(P2W-TW){tv[j][TW-1]}}, tv[j]}) *
                   $signed({{(P2W-cgnbm_pkg::SIGMA_W){1'b0}}, sigma_r});
      end
    end
    if (rdy[S_F3]) begin
      out_real_r <= sat[0];
      out_imag_r <= sat[1];
    end
  end

  assign out_noise_real = out_real_r;
  assign out_noise_imag = out_imag_r;

  // a stalled input means every stage holds a request and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |-> (out_valid && out_stall && (&vld_r)))
    else $error("input stalled while the pipeline has room");

  // a full, blocked pipeline does not move
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && (&vld_r)) |=> $stable(vld_r))
    else $error("stage valid bits moved under a full stall");

  // a taken result frees the last stage unless a new request enters it
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !vld_r[NST-2]) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule
`default_nettype wire

@@ hw/rtl/cgnbm_log_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Log cell
// One squaring step of the -log2 mantissa recurrence; yields one fraction bit.
// ----------------------------------------------------------------------------
module cgnbm_log_cell #(
  parameter int PW = 5
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic [30:0]                          x_in,
  input  wire logic [cgnbm_pkg::ITER_STEPS-1:0]     frac_in,
  input  wire logic [PW-1:0]                        p_in,
  output logic      [30:0]                          x_r,
  output logic      [cgnbm_pkg::ITER_STEPS-1:0]     frac_r,
  output logic      [PW-1:0]                        p_r
);

  logic [61:0] sq;
  logic [31:0] y;
  logic [30:0] x_nxt;
  logic        bit_nxt;

  always_comb begin
    sq = 62'(x_in) * 62'(x_in);
    y  = sq[61:30];
    bit_nxt = y[31];
    if (y[31]) begin
      x_nxt = y[31:1];
    end else begin
      x_nxt = y[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      frac_r <= {frac_in[cgnbm_pkg::ITER_STEPS-2:0], bit_nxt};
      p_r    <= p_in;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cgnbm_cordic_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation step of the angle recurrence in turns.
// ----------------------------------------------------------------------------
module cgnbm_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic signed [cgnbm_pkg::CORDIC_W-1:0] x_in,
  input  wire logic signed [cgnbm_pkg::CORDIC_W-1:0] y_in,
  input  wire logic signed [cgnbm_pkg::CORDIC_W-1:0] z_in,
  input  wire logic        [1:0]                     q_in,
  output logic      signed [cgnbm_pkg::CORDIC_W-1:0] x_r,
  output logic      signed [cgnbm_pkg::CORDIC_W-1:0] y_r,
  output logic      signed [cgnbm_pkg::CORDIC_W-1:0] z_r,
  output logic             [1:0]                     q_r
);

  localparam logic signed [cgnbm_pkg::CORDIC_W-1:0] ANG =
    $signed(cgnbm_pkg::CORDIC_W'(cgnbm_pkg::ATAN_TURNS[IDX]));

  logic signed [cgnbm_pkg::CORDIC_W-1:0] dx, dy, x_nxt, y_nxt, z_nxt;

  always_comb begin
    dx = y_in >>> IDX;
    dy = x_in >>> IDX;
    if (!z_in[cgnbm_pkg::CORDIC_W-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ANG;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      q_r <= q_in;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cgnbm_sqrt_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Square root cell
// One result bit of a digit-by-digit integer square root; carries a tag along.
// ----------------------------------------------------------------------------
module cgnbm_sqrt_cell #(
  parameter int SQ  = 27,
  parameter int IDX = 0,
  parameter int TW  = 68
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [2*SQ-1:0]     v_in,
  input  wire logic [SQ+1:0]       rem_in,
  input  wire logic [SQ-1:0]       res_in,
  input  wire logic [TW-1:0]       tag_in,
  output logic      [2*SQ-1:0]     v_r,
  output logic      [SQ+1:0]       rem_r,
  output logic      [SQ-1:0]       res_r,
  output logic      [TW-1:0]       tag_r
);

  logic [SQ+1:0] rem_sh, trial, rem_nxt;
  logic [SQ-1:0] res_nxt;

  always_comb begin
    rem_sh = {rem_in[SQ-1:0], v_in[2*(SQ-1-IDX)+1 -: 2]};
    trial  = {res_in, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt = rem_sh - trial;
      res_nxt = {res_in[SQ-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh;
      res_nxt = {res_in[SQ-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_in;
      rem_r <= rem_nxt;
      res_r <= res_nxt;
      tag_r <= tag_in;
    end
  end

endmodule
`default_nettype wire

@@ test/noise_checker.sv @@
// ----------------------------------------------------------------------------
// Noise sample checker
// Watches the request and sample channels of the Box-Muller noise generator,
// computes the expected complex sample for every accepted request in fixed
// point, and compares each accepted sample field by field in order.
// ----------------------------------------------------------------------------
module noise_checker #(
  parameter int UNIFORM_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_stall,
  input  wire logic [15:0]                          in_uniform_a,
  input  wire logic [15:0]                          in_uniform_b,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_stall,
  input  wire logic signed [cgnbm_pkg::OUT_W-1:0]   out_noise_real,
  input  wire logic signed [cgnbm_pkg::OUT_W-1:0]   out_noise_imag,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [cgnbm_pkg::SIGMA_W-1:0]        cfg_wr_data,
  output int                                        fail_count,
  output int                                        pending_count
);
  import cgnbm_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
  } sample_t;

  logic [SIGMA_W-1:0] sigma_q;
  sample_t            sample_q[$];

  function automatic longint unsigned neg_log2_q24(longint unsigned m);
    int unsigned     p;
    longint unsigned x;
    longint unsigned frac;
    p = 0;
    frac = 0;
    while (p < 62 && (m >> (p + 1)) != 0) p++;
    if (p <= 30) x = m << (30 - p);
    else x = m >> (p - 30);
    for (int i = 0; i < ITER_STEPS; i++) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= (64'd1 << 31)) begin
        frac = frac | 1;
        x = x >> 1;
      end
    end
    return (longint'(UNIFORM_BITS - p) << 24) - frac;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [OUT_W-1:0] scale_part(longint rad, longint trig,
                                                         logic [SIGMA_W-1:0] sg);
    longint t;
    t = (rad * trig + (64'sd1 <<< 29)) >>> 30;
    t = (t * longint'({48'd0, sg}) + (64'sd1 <<< 19)) >>> 20;
    if (t > 8388607) t = 8388607;
    if (t < -8388608) t = -8388608;
    return t[OUT_W-1:0];
  endfunction

  function automatic sample_t gaussian_sample(logic [15:0] ua, logic [15:0] ub,
                                              logic [SIGMA_W-1:0] sg);
    longint unsigned full_w;
    longint unsigned m;
    longint unsigned n;
    longint unsigned r2;
    longint          rad;
    logic [31:0]     phase;
    longint          x;
    longint          y;
    longint          z;
    longint          dx;
    longint          dy;
    longint          c;
    longint          s;
    sample_t         res;
    full_w = 64'd1 << UNIFORM_BITS;
    m = full_w - (longint'(ua) & (full_w - 1));
    n = full_w - (longint'(ub) & (full_w - 1));
    r2 = (neg_log2_q24(m) * longint'(LN2_Q32)) >> 31;
    rad = int_sqrt(r2 << 24);
    phase = 32'(n << (32 - UNIFORM_BITS));
    z = longint'(phase[29:0]);
    x = longint'(INV_GAIN_Q30);
    y = 0;
    for (int i = 0; i < ITER_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    case (phase[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    res.re = scale_part(rad, c, sg);
    res.im = scale_part(rad, s, sg);
    return res;
  endfunction

  assign pending_count = sample_q.size();

  always @(posedge clk) begin
    sample_t exp_s;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      sigma_q <= SIGMA_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) sigma_q <= cfg_wr_data;
      if (in_valid && !in_stall)
        sample_q.push_back(gaussian_sample(in_uniform_a, in_uniform_b, sigma_q));
      if (out_valid && !out_stall) begin
        if (sample_q.size() == 0) begin
          $error("noise sample with no request pending");
          errs++;
        end else begin
          exp_s = sample_q.pop_front();
          if (out_noise_real !== exp_s.re) begin
            $error("noise_real expected %0d actual %0d", exp_s.re, out_noise_real);
            errs++;
          end
          if (out_noise_imag !== exp_s.im) begin
            $error("noise_imag expected %0d actual %0d", exp_s.im, out_noise_imag);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Noise generator testbench
// Drives directed and random uniform code pairs in bursts under several sigma
// settings, stalls the sample side on its own pattern with one long hold-off,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import cgnbm_pkg::*;

  localparam int DRAIN_CYCLES = 100;
  localparam int STUCK_LIMIT  = 2000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [15:0]             in_uniform_a = '0;
  logic [15:0]             in_uniform_b = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_noise_real;
  logic signed [OUT_W-1:0] out_noise_imag;
  logic                    cfg_wr_en = 1'b0;
  logic [SIGMA_W-1:0]      cfg_wr_data = '0;
  int                      fail_count;
  int                      pending_count;
  int                      idle_cycles = 0;
  bit                      long_hold = 1'b0;

  always #2 clk = ~clk;

  complex_gaussian_noise_box_muller uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_uniform_a(in_uniform_a), .in_uniform_b(in_uniform_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_noise_real(out_noise_real), .out_noise_imag(out_noise_imag),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  noise_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_uniform_a(in_uniform_a), .in_uniform_b(in_uniform_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_noise_real(out_noise_real), .out_noise_imag(out_noise_imag),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    int mode;
    int hold;
    if (long_hold) begin
      out_stall <= 1'b1;
      for (hold = 0; hold < 150; hold++) @(posedge clk);
      out_stall <= 1'b0;
      long_hold = 1'b0;
    end else begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
      for (hold = $urandom_range(0, 12); hold > 0; hold--) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STUCK_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic send_request(logic [15:0] ua, logic [15:0] ub);
    in_valid <= 1'b1;
    in_uniform_a <= ua;
    in_uniform_b <= ub;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_and_set_sigma(logic [SIGMA_W-1:0] sg);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= sg;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_burst_run(int count);
    int burst;
    int sent;
    logic [15:0] ua;
    logic [15:0] ub;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < count; k++) begin
        case ($urandom_range(0, 5))
          0: ua = 16'($urandom_range(0, 15));
          1: ua = 16'hFFFF - 16'($urandom_range(0, 15));
          default: ua = 16'($urandom);
        endcase
        ub = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 3)) << 14
                                         : 16'($urandom);
        send_request(ua, ub);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 15));
    end
  endtask

  initial begin
    logic [15:0] edge_codes [8];
    logic [SIGMA_W-1:0] sigma_set [6];
    edge_codes = '{16'h0000, 16'h0001, 16'h4000, 16'h8000, 16'hC000,
                   16'hFFFE, 16'hFFFF, 16'h5555};
    sigma_set = '{16'hFFFF, 16'h0000, 16'h00FF, 16'h0001, 16'h0100, 16'h8AC3};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 8; i++) send_request(edge_codes[i], edge_codes[(i * 3) % 8]);
    for (int i = 0; i < 8; i++) send_request(edge_codes[7 - i], edge_codes[i]);
    send_request(16'hFFFF, 16'h0000);
    send_request(16'h0000, 16'hFFFF);

    long_hold = 1'b1;
    random_burst_run(300);
    foreach (sigma_set[s]) begin
      drain_and_set_sigma(sigma_set[s]);
      send_request(16'hFFFF, 16'h0000);
      send_request(16'hFFFF, 16'hA000);
      random_burst_run(160);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/cgnbm_pkg.sv
hw/rtl/cgnbm_log_cell.sv
hw/rtl/cgnbm_cordic_cell.sv
hw/rtl/cgnbm_sqrt_cell.sv
hw/rtl/complex_gaussian_noise_box_muller.sv
test/noise_checker.sv
test/tb_top.sv
